// File: hw/rtl/dibipd_pkg.sv
// ----------------------------------------------------------------------------
// dibipd_pkg: shared types and constants of the icon pixel decoder
// Holds the decode descriptor, result record, palette write record and codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dibipd_pkg;

  // sizing
  localparam int MAX_WIDTH     = 256;
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int DQ_DEPTH      = 4;
  localparam int DQ_AW         = $clog2(DQ_DEPTH);
  localparam int DQ_CW         = $clog2(DQ_DEPTH + 1);
  localparam int OQ_DEPTH      = 4;
  localparam int OQ_AW         = $clog2(OQ_DEPTH);
  localparam int OQ_CW         = $clog2(OQ_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_PIXEL_MODE   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

  // pixel modes
  localparam logic [2:0] MODE_1BPP  = 3'd0;
  localparam logic [2:0] MODE_4BPP  = 3'd1;
  localparam logic [2:0] MODE_8BPP  = 3'd2;
  localparam logic [2:0] MODE_24BPP = 3'd3;
  localparam logic [2:0] MODE_32BPP = 3'd4;

  // descriptor operations
  localparam logic [2:0] OP_PAL1 = 3'd0;
  localparam logic [2:0] OP_PAL4 = 3'd1;
  localparam logic [2:0] OP_PAL8 = 3'd2;
  localparam logic [2:0] OP_RGB  = 3'd3;
  localparam logic [2:0] OP_RGBA = 3'd4;
  localparam logic [2:0] OP_MASK = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_COLOR = 2'd0;
  localparam logic [1:0] KIND_RGBA  = 2'd1;
  localparam logic [1:0] KIND_MASK  = 2'd2;

  // one descriptor: a decoded byte of up to eight pixels, or one direct color pixel
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  data;
    logic [23:0] color;
    logic [7:0]  col0;
    logic [7:0]  row;
    logic [3:0]  cnt;
  } desc_t;

  // one result transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [23:0] color;
    logic [7:0]  alpha;
    logic        last;
  } res_t;

  // palette load write
  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] addr;
    logic [23:0]       data;
  } pal_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/dibipd_front.sv
// ----------------------------------------------------------------------------
// dibipd_front: byte classifier of the icon pixel decoder
// Tracks phase, row and byte position, loads the palette and turns each in-width
// packed pixel or mask byte, and each direct color pixel, into one descriptor for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dibipd_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  q_full,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [8:0]            cfg_wdata,
  output dibipd_pkg::desc_t          desc,
  output logic                       desc_push,
  output dibipd_pkg::pal_wr_t        pal_wr
);

  localparam logic [1:0] PH_PALETTE = 2'd0;
  localparam logic [1:0] PH_PIXELS  = 2'd1;
  localparam logic [1:0] PH_MASK    = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  logic [2:0]  mode_r, mode_nxt;
  logic [8:0]  width_r, width_nxt;
  logic [8:0]  height_r, height_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [10:0] pal_cnt_r, pal_cnt_nxt;
  logic [11:0] rbc_r, rbc_nxt;
  logic [8:0]  row_cnt_r, row_cnt_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [1:0]  lane_r, lane_nxt;
  logic [7:0]  pcol_r, pcol_nxt;

  logic        accept;
  logic [2:0]  eff_mode;
  logic [15:0] w16;
  logic [8:0]  h_eff;
  logic [15:0] pix_bits;
  logic [15:0] pix_stride;
  logic [15:0] mask_stride;
  logic [15:0] stride;
  logic [15:0] bpw;
  logic [2:0]  bpp;
  logic [10:0] pal_end;
  logic [10:0] pal_cnt_inc;
  logic [8:0]  pal_idx;
  logic [15:0] x0;
  logic [15:0] cap;
  logic [15:0] rem;
  logic [2:0]  op;
  logic [7:0]  row_lo;
  logic [11:0] rbc_inc;
  logic [8:0]  row_inc;
  logic        restart;

  assign accept = in_push && !q_full;

  // effective configuration
  assign eff_mode = (mode_r > dibipd_pkg::MODE_32BPP) ? dibipd_pkg::MODE_32BPP : mode_r;

  always_comb begin
    if (width_r == 9'd0) begin
      w16 = 16'd1;
    end else if (16'(width_r) > 16'(dibipd_pkg::MAX_WIDTH)) begin
      w16 = 16'(dibipd_pkg::MAX_WIDTH);
    end else begin
      w16 = 16'(width_r);
    end
  end

  always_comb begin
    if (height_r == 9'd0) begin
      h_eff = 9'd1;
    end else if (height_r > 9'd256) begin
      h_eff = 9'd256;
    end else begin
      h_eff = height_r;
    end
  end

  // row strides padded to 32 bits
  always_comb begin
    case (eff_mode)
      dibipd_pkg::MODE_1BPP:  pix_bits = w16;
      dibipd_pkg::MODE_4BPP:  pix_bits = w16 << 2;
      dibipd_pkg::MODE_8BPP:  pix_bits = w16 << 3;
      dibipd_pkg::MODE_24BPP: pix_bits = (w16 << 4) + (w16 << 3);
      default:                pix_bits = w16 << 5;
    endcase
  end

  assign pix_stride  = ((pix_bits + 16'd31) >> 5) << 2;
  assign mask_stride = ((w16 + 16'd31) >> 5) << 2;
  assign stride      = (phase_r == PH_MASK) ? mask_stride : pix_stride;

  // direct color geometry
  assign bpp = (eff_mode == dibipd_pkg::MODE_24BPP) ? 3'd3 : 3'd4;
  assign bpw = (eff_mode == dibipd_pkg::MODE_24BPP) ? ((w16 << 1) + w16) : (w16 << 2);

  // palette length in bytes
  always_comb begin
    case (eff_mode)
      dibipd_pkg::MODE_1BPP: pal_end = 11'd8;
      dibipd_pkg::MODE_4BPP: pal_end = 11'd64;
      default:               pal_end = 11'd1024;
    endcase
  end

  assign pal_cnt_inc = pal_cnt_r + 11'd1;
  assign pal_idx     = pal_cnt_r[10:2];
  assign row_lo      = 8'(h_eff - 9'd1 - row_cnt_r);
  assign rbc_inc     = rbc_r + 12'd1;
  assign row_inc     = row_cnt_r + 9'd1;

  // packed pixel geometry: first column and pixels per byte
  always_comb begin
    if (phase_r == PH_MASK) begin
      op  = dibipd_pkg::OP_MASK;
      x0  = 16'(rbc_r) << 3;
      cap = 16'd8;
    end else begin
      case (eff_mode)
        dibipd_pkg::MODE_1BPP: begin
          op  = dibipd_pkg::OP_PAL1;
          x0  = 16'(rbc_r) << 3;
          cap = 16'd8;
        end
        dibipd_pkg::MODE_4BPP: begin
          op  = dibipd_pkg::OP_PAL4;
          x0  = 16'(rbc_r) << 1;
          cap = 16'd2;
        end
        dibipd_pkg::MODE_8BPP: begin
          op  = dibipd_pkg::OP_PAL8;
          x0  = 16'(rbc_r);
          cap = 16'd1;
        end
        dibipd_pkg::MODE_24BPP: begin
          op  = dibipd_pkg::OP_RGB;
          x0  = 16'(rbc_r);
          cap = 16'd1;
        end
        default: begin
          op  = dibipd_pkg::OP_RGBA;
          x0  = 16'(rbc_r);
          cap = 16'd1;
        end
      endcase
    end
  end

  assign rem = w16 - x0;

  // byte sequencing
  always_comb begin
    mode_nxt    = mode_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    phase_nxt   = phase_r;
    pal_cnt_nxt = pal_cnt_r;
    rbc_nxt     = rbc_r;
    row_cnt_nxt = row_cnt_r;
    asm_nxt     = asm_r;
    lane_nxt    = lane_r;
    pcol_nxt    = pcol_r;
    restart     = 1'b0;
    desc_push   = 1'b0;
    desc        = '0;
    pal_wr      = '0;

    desc.op   = op;
    desc.data = in_data_byte;
    desc.row  = row_lo;

    if (cfg_we) begin
      case (cfg_index)
        dibipd_pkg::CFG_PIXEL_MODE: begin
          mode_nxt = cfg_wdata[2:0];
          restart  = 1'b1;
        end
        dibipd_pkg::CFG_IMAGE_WIDTH: begin
          width_nxt = cfg_wdata;
          restart   = 1'b1;
        end
        dibipd_pkg::CFG_IMAGE_HEIGHT: begin
          height_nxt = cfg_wdata;
          restart    = 1'b1;
        end
        default: ;
      endcase
    end else if (accept) begin
      case (phase_r)
        PH_PALETTE: begin
          // gather blue, green, red; store on the reserved byte
          case (pal_cnt_r[1:0])
            2'd0: asm_nxt = {16'h0000, in_data_byte};
            2'd1: asm_nxt = asm_r | {8'h00, in_data_byte, 8'h00};
            2'd2: asm_nxt = asm_r | {in_data_byte, 16'h0000};
            default: begin
              if (pal_idx < 9'(dibipd_pkg::PALETTE_DEPTH)) begin
                pal_wr.we   = 1'b1;
                pal_wr.addr = pal_idx[dibipd_pkg::PAL_AW-1:0];
                pal_wr.data = asm_r;
              end
            end
          endcase
          if (pal_cnt_inc >= pal_end) begin
            pal_cnt_nxt = 11'd0;
            asm_nxt     = 24'h000000;
            phase_nxt   = PH_PIXELS;
          end else begin
            pal_cnt_nxt = pal_cnt_inc;
          end
        end

        PH_PIXELS, PH_MASK: begin
          if (op == dibipd_pkg::OP_RGB || op == dibipd_pkg::OP_RGBA) begin
            // direct color: assemble bytes into one pixel
            if (16'(rbc_r) < bpw) begin
              case (lane_r)
                2'd0: asm_nxt = {16'h0000, in_data_byte};
                2'd1: asm_nxt = asm_r | {8'h00, in_data_byte, 8'h00};
                2'd2: asm_nxt = asm_r | {in_data_byte, 16'h0000};
                default: ;
              endcase
              if (3'({1'b0, lane_r}) + 3'd1 == bpp) begin
                desc_push  = 1'b1;
                desc.color = asm_nxt;
                desc.col0  = pcol_r;
                desc.cnt   = 4'd1;
                lane_nxt   = 2'd0;
                pcol_nxt   = pcol_r + 8'd1;
              end else begin
                lane_nxt = lane_r + 2'd1;
              end
            end
          end else if (x0 < w16) begin
            // packed pixels or mask bits
            desc_push = 1'b1;
            desc.col0 = x0[7:0];
            desc.cnt  = (rem > cap) ? cap[3:0] : rem[3:0];
          end

          // row and phase advance
          if (16'(rbc_inc) >= stride) begin
            rbc_nxt  = 12'd0;
            lane_nxt = 2'd0;
            asm_nxt  = 24'h000000;
            pcol_nxt = 8'd0;
            if (row_inc >= h_eff) begin
              row_cnt_nxt = 9'd0;
              if (phase_r == PH_PIXELS && eff_mode != dibipd_pkg::MODE_32BPP) begin
                phase_nxt = PH_MASK;
              end else begin
                phase_nxt = PH_DONE;
              end
            end else begin
              row_cnt_nxt = row_inc;
            end
          end else begin
            rbc_nxt = rbc_inc;
          end
        end

        default: ;
      endcase
    end

    // a write to the mode, width or height register starts decoding over
    if (restart) begin
      phase_nxt   = (mode_nxt <= dibipd_pkg::MODE_8BPP) ? PH_PALETTE : PH_PIXELS;
      pal_cnt_nxt = 11'd0;
      rbc_nxt     = 12'd0;
      row_cnt_nxt = 9'd0;
      asm_nxt     = 24'h000000;
      lane_nxt    = 2'd0;
      pcol_nxt    = 8'd0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= dibipd_pkg::MODE_1BPP;
      width_r   <= 9'd32;
      height_r  <= 9'd32;
      phase_r   <= PH_PALETTE;
      pal_cnt_r <= 11'd0;
      rbc_r     <= 12'd0;
      row_cnt_r <= 9'd0;
      asm_r     <= 24'h000000;
      lane_r    <= 2'd0;
      pcol_r    <= 8'd0;
    end else begin
      mode_r    <= mode_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      phase_r   <= phase_nxt;
      pal_cnt_r <= pal_cnt_nxt;
      rbc_r     <= rbc_nxt;
      row_cnt_r <= row_cnt_nxt;
      asm_r     <= asm_nxt;
      lane_r    <= lane_nxt;
      pcol_r    <= pcol_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dibipd_desc_q.sv
// ----------------------------------------------------------------------------
// dibipd_desc_q: descriptor queue between front and back end
// Small register queue that lets the front end run ahead of pixel output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dibipd_desc_q (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  dibipd_pkg::desc_t      push_data,
  output logic                   full,
  input  wire logic              pop,
  output dibipd_pkg::desc_t      head,
  output logic                   head_valid
);

  dibipd_pkg::desc_t              mem_r [dibipd_pkg::DQ_DEPTH];
  logic [dibipd_pkg::DQ_AW-1:0]   wr_ptr_r;
  logic [dibipd_pkg::DQ_AW-1:0]   rd_ptr_r;
  logic [dibipd_pkg::DQ_CW-1:0]   cnt_r;
  logic [dibipd_pkg::DQ_CW-1:0]   cnt_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (cnt_r == dibipd_pkg::DQ_CW'(dibipd_pkg::DQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dibipd_back.sv
// ----------------------------------------------------------------------------
// dibipd_back: pixel issue back end of the icon pixel decoder
// Walks each descriptor one pixel a cycle while the output queue has room,
// looks colors up in the palette memory and queues finished results for the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dibipd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  dibipd_pkg::pal_wr_t    pal_wr,
  input  dibipd_pkg::desc_t      head,
  input  wire logic              head_valid,
  output logic                   head_pop,
  output dibipd_pkg::res_t       out_res,
  output logic                   out_empty,
  input  wire logic              out_pop
);

  // palette memory
  logic [23:0]                    pal_mem [dibipd_pkg::PALETTE_DEPTH];
  logic [23:0]                    pal_rd_r;
  logic [dibipd_pkg::PAL_AW-1:0]  pal_rd_addr;

  // issue stage
  logic [2:0]                     k_r, k_nxt;
  logic                           issue;
  logic                           last_k;
  logic [dibipd_pkg::OQ_CW:0]     room_sum;
  logic                           bit_k;
  logic [7:0]                     pal_idx;
  dibipd_pkg::res_t               iss_res;
  logic                           iss_use_pal;

  // lookup stage
  logic                           b_valid_r;
  dibipd_pkg::res_t               b_res_r;
  logic                           b_use_pal_r;
  logic                           b_pal_ok_r;
  dibipd_pkg::res_t               b_final;

  // output queue
  dibipd_pkg::res_t               oq_r [dibipd_pkg::OQ_DEPTH];
  logic [dibipd_pkg::OQ_AW-1:0]   oq_wr_r;
  logic [dibipd_pkg::OQ_AW-1:0]   oq_rd_r;
  logic [dibipd_pkg::OQ_CW-1:0]   ocnt_r, ocnt_nxt;
  logic                           oq_pop;

  // issue only with room reserved for the transaction in flight
  assign room_sum = {1'b0, ocnt_r} + (dibipd_pkg::OQ_CW + 1)'(b_valid_r);
  assign issue    = head_valid && (room_sum < (dibipd_pkg::OQ_CW + 1)'(dibipd_pkg::OQ_DEPTH));
  assign last_k   = (4'(k_r) + 4'd1 == head.cnt);
  assign head_pop = issue && last_k;

  always_comb begin
    k_nxt = k_r;
    if (issue) begin
      k_nxt = last_k ? 3'd0 : k_r + 3'd1;
    end
  end

  // pixel k of the current descriptor
  assign bit_k = head.data[3'd7 - k_r];

  always_comb begin
    case (head.op)
      dibipd_pkg::OP_PAL1: pal_idx = {7'h00, bit_k};
      dibipd_pkg::OP_PAL4: pal_idx = k_r[0] ? {4'h0, head.data[3:0]} : {4'h0, head.data[7:4]};
      default:             pal_idx = head.data;
    endcase
  end

  assign pal_rd_addr = pal_idx[dibipd_pkg::PAL_AW-1:0];

  always_comb begin
    iss_res        = '0;
    iss_use_pal    = 1'b0;
    iss_res.column = head.col0 + 8'(k_r);
    iss_res.row    = head.row;
    iss_res.last   = last_k;
    case (head.op)
      dibipd_pkg::OP_PAL1, dibipd_pkg::OP_PAL4, dibipd_pkg::OP_PAL8: begin
        iss_res.kind = dibipd_pkg::KIND_COLOR;
        iss_use_pal  = 1'b1;
      end
      dibipd_pkg::OP_RGB: begin
        iss_res.kind  = dibipd_pkg::KIND_COLOR;
        iss_res.color = head.color;
      end
      dibipd_pkg::OP_RGBA: begin
        iss_res.kind  = dibipd_pkg::KIND_RGBA;
        iss_res.color = head.color;
        iss_res.alpha = head.data;
      end
      default: begin
        iss_res.kind  = dibipd_pkg::KIND_MASK;
        iss_res.alpha = bit_k ? 8'h00 : 8'hFF;
      end
    endcase
  end

  // palette write and registered read
  always_ff @(posedge clk) begin
    if (pal_wr.we) begin
      pal_mem[pal_wr.addr] <= pal_wr.data;
    end
    pal_rd_r <= pal_mem[pal_rd_addr];
  end

  // lookup stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= 3'd0;
      b_valid_r <= 1'b0;
    end else begin
      k_r       <= k_nxt;
      b_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_res_r     <= iss_res;
      b_use_pal_r <= iss_use_pal;
      b_pal_ok_r  <= (9'(pal_idx) < 9'(dibipd_pkg::PALETTE_DEPTH));
    end
  end

  // merge palette color
  always_comb begin
    b_final = b_res_r;
    if (b_use_pal_r) begin
      b_final.color = b_pal_ok_r ? pal_rd_r : 24'h000000;
    end
  end

  // output queue
  assign out_empty = (ocnt_r == '0);
  assign out_res   = oq_r[oq_rd_r];
  assign oq_pop    = out_pop && !out_empty;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (b_valid_r && !oq_pop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (oq_pop && !b_valid_r) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r <= '0;
      oq_rd_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (b_valid_r) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      oq_r[oq_wr_r] <= b_final;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dib_icon_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// dib_icon_pixel_decoder_core: icon bitmap palette and pixel unpacker
// Path: a byte's descriptor goes through the descriptor queue, lookup stage and output queue.
// Throughput: one result per cycle from the single pixel issue unit in the
// back end while the output queue has room; a byte yields up to 8 results
// (1-bit pixel and mask bytes), palette and padding bytes yield none.
// Reset: synchronous; queues empty, registers 1 bpp, 32 x 32, palette phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dib_icon_pixel_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_pixel_kind,
  output logic [7:0]       out_column,
  output logic [7:0]       out_row,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata
);

  dibipd_pkg::desc_t   desc;
  logic                desc_push;
  dibipd_pkg::pal_wr_t pal_wr;
  logic                q_full;
  dibipd_pkg::desc_t   head;
  logic                head_valid;
  logic                head_pop;
  dibipd_pkg::res_t    out_res;

  assign in_full = q_full;

  // byte classifier
  dibipd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .desc         (desc),
    .desc_push    (desc_push),
    .pal_wr       (pal_wr)
  );

  // decoupling queue
  dibipd_desc_q u_desc_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (desc_push),
    .push_data  (desc),
    .full       (q_full),
    .pop        (head_pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // pixel issue and output queue
  dibipd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pal_wr     (pal_wr),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .out_res    (out_res),
    .out_empty  (out_empty),
    .out_pop    (out_pop)
  );

  // result fields
  assign out_pixel_kind = out_res.kind;
  assign out_column     = out_res.column;
  assign out_row        = out_res.row;
  assign out_red        = out_res.color[23:16];
  assign out_green      = out_res.color[15:8];
  assign out_blue       = out_res.color[7:0];
  assign out_alpha      = out_res.alpha;
  assign out_last       = out_res.last;

endmodule

`default_nettype wire

// File: hw/rtl/dibipd_checker.sv
// ----------------------------------------------------------------------------
// dibipd_checker: port level checks of the icon pixel decoder
// Watches the result side for reset behavior and field consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dibipd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_empty,
  input wire logic [1:0] out_pixel_kind,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue,
  input wire logic [7:0] out_alpha
);

  // reset drains the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // only defined kinds leave the block
  a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_pixel_kind == dibipd_pkg::KIND_COLOR ||
                    out_pixel_kind == dibipd_pkg::KIND_RGBA ||
                    out_pixel_kind == dibipd_pkg::KIND_MASK))
    else $error("undefined pixel kind on result transaction");

  // mask transactions carry no color and a full or empty alpha
  a_mask_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pixel_kind == dibipd_pkg::KIND_MASK) |->
      (out_red == 8'h00 && out_green == 8'h00 && out_blue == 8'h00 &&
       (out_alpha == 8'h00 || out_alpha == 8'hFF)))
    else $error("mask transaction with bad fields");

  // plain color transactions carry no alpha
  a_color_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pixel_kind == dibipd_pkg::KIND_COLOR) |-> out_alpha == 8'h00)
    else $error("color transaction with nonzero alpha");

endmodule

bind dib_icon_pixel_decoder_core dibipd_checker u_dibipd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_empty      (out_empty),
  .out_pixel_kind (out_pixel_kind),
  .out_red        (out_red),
  .out_green      (out_green),
  .out_blue       (out_blue),
  .out_alpha      (out_alpha)
);

`default_nettype wire
